>>> rtl/lzbd_pkg.sv
// lzbd_pkg: shared types and constants of the LZ byte stream decompressor.
// No dependencies; used by lz_byte_stream_decompressor.
package lzbd_pkg;

   localparam int WINDOW_BYTES     = 4096;
   localparam int WIN_AW           = $clog2(WINDOW_BYTES);
   localparam int BYTES_PER_RESULT = 8;
   localparam int CNT_W            = 4;
   localparam int HDR_BYTES        = 16;
   localparam int EXT_LEN_BIAS     = 18;
   localparam int NIB_LEN_BIAS     = 2;

   // status codes on the result channel
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_MAGIC    = 2'd1;
   localparam logic [1:0] STAT_DISTANCE = 2'd2;
   localparam logic [1:0] STAT_TRUNC    = 2'd3;

   // decode phase of the compressed stream
   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_CODE   = 6'b000010,
      PH_ITEM   = 6'b000100,
      PH_REFLO  = 6'b001000,
      PH_REFEXT = 6'b010000,
      PH_SKIP   = 6'b100000
   } phase_type;

   // sequencer state
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RD   = 5'b00010,
      ST_WR   = 5'b00100,
      ST_FIN  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   // expected magic bytes of the header
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0:    m = 8'h59;
         2'd1:    m = 8'h61;
         2'd2:    m = 8'h7A;
         default: m = 8'h30;
      endcase
      return m;
   endfunction

endpackage

>>> rtl/lzbd_ram.sv
// lzbd_ram: generic single write, single read RAM with registered read data.
// No dependencies.
module lzbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lz_byte_stream_decompressor.sv
// lz_byte_stream_decompressor: streaming LZ77 (Yaz0 format) decoder top level.
// Depends on lzbd_pkg and lzbd_ram (4096 x 8 history).
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_in_byte, req_last_in
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_out_bytes, rsp_byte_count, rsp_status,
//          |           |                      | rsp_frame_end, rsp_run_last
//
// Each byte is taken in the idle state and closed in the finish state, which presents any result.
// A back-reference copies byte by byte, with a history read and then a write back per byte,
// and a full mid-copy chunk is flushed as its own result before the copy goes on.
// Reset is synchronous and clears the control state; the history is never cleared.
// A stalled result holds the sequencer; no input is taken until every result has gone.
module lz_byte_stream_decompressor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_byte_count,
   output logic [1:0]  rsp_status,
   output logic        rsp_frame_end,
   output logic        rsp_run_last
);

   localparam int AW = lzbd_pkg::WIN_AW;

   lzbd_pkg::state_type state_ff, state_in;
   lzbd_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  hdr_ff, hdr_in;
   logic [31:0] exp_ff, exp_in;
   logic [31:0] prod_ff, prod_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [7:0]  code_ff, code_in;
   logic [3:0]  rem_ff, rem_in;
   logic [7:0]  fref_ff, fref_in;
   logic [AW-1:0] dist_ff, dist_in;
   logic [8:0]  left_ff, left_in;
   logic [63:0] chunk_ff, chunk_in;
   logic [lzbd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]  st_ff, st_in;
   logic        ended_ff, ended_in;
   logic        last_ff, last_in;
   logic        fin_elem_ff, fin_elem_in;
   logic        final_ff, final_in;
   logic [63:0] obytes_ff, obytes_in;
   logic [lzbd_pkg::CNT_W-1:0] ocnt_ff, ocnt_in;
   logic [1:0]  ost_ff, ost_in;
   logic        oend_ff, oend_in;
   logic        olast_ff, olast_in;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata, mem_rdata;

   // scratch values of the next-state logic
   logic [31:0]   exp_v;
   logic [4:0]    hdr_v;
   logic [AW-1:0] d_v;
   logic [3:0]    rem_v;
   logic [1:0]    st_v;
   logic          end_v;
   lzbd_pkg::phase_type ph_v;

   lzbd_ram #(
      .WIDTH (8),
      .DEPTH (lzbd_pkg::WINDOW_BYTES)
   ) u_hist (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready      = (state_ff == lzbd_pkg::ST_IDLE);
   assign rsp_valid      = (state_ff == lzbd_pkg::ST_OUT);
   assign rsp_out_bytes  = obytes_ff;
   assign rsp_byte_count = ocnt_ff;
   assign rsp_status     = ost_ff;
   assign rsp_frame_end  = oend_ff;
   assign rsp_run_last   = olast_ff;

   // decode sequencer
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      hdr_in      = hdr_ff;
      exp_in      = exp_ff;
      prod_in     = prod_ff;
      wp_in       = wp_ff;
      code_in     = code_ff;
      rem_in      = rem_ff;
      fref_in     = fref_ff;
      dist_in     = dist_ff;
      left_in     = left_ff;
      chunk_in    = chunk_ff;
      cnt_in      = cnt_ff;
      st_in       = st_ff;
      ended_in    = ended_ff;
      last_in     = last_ff;
      fin_elem_in = fin_elem_ff;
      final_in    = final_ff;
      obytes_in   = obytes_ff;
      ocnt_in     = ocnt_ff;
      ost_in      = ost_ff;
      oend_in     = oend_ff;
      olast_in    = olast_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = wp_ff;
      mem_wdata   = mem_rdata;
      mem_raddr   = wp_ff - dist_ff - AW'(1);
      exp_v       = exp_ff;
      hdr_v       = hdr_ff;
      d_v         = {fref_ff[3:0], req_in_byte};
      rem_v       = rem_ff;
      st_v        = st_ff;
      end_v       = ended_ff;
      ph_v        = phase_ff;

      case (state_ff)
         lzbd_pkg::ST_IDLE: begin
            // take one compressed byte and decode it
            if (req_valid) begin
               last_in     = req_last_in;
               st_in       = lzbd_pkg::STAT_OK;
               ended_in    = 1'b0;
               fin_elem_in = 1'b0;
               cnt_in      = '0;
               chunk_in    = '0;
               state_in    = lzbd_pkg::ST_FIN;
               case (phase_ff)
                  lzbd_pkg::PH_HEADER: begin
                     if (hdr_ff < 5'd4 &&
                         req_in_byte != lzbd_pkg::magic_byte(hdr_ff[1:0])) begin
                        st_in    = lzbd_pkg::STAT_MAGIC;
                        ended_in = 1'b1;
                        phase_in = lzbd_pkg::PH_SKIP;
                     end else begin
                        if (hdr_ff >= 5'd4 && hdr_ff < 5'd8) begin
                           exp_v = {exp_ff[23:0], req_in_byte};
                        end
                        exp_in = exp_v;
                        hdr_v  = hdr_ff + 5'd1;
                        hdr_in = hdr_v;
                        if (hdr_v == 5'(lzbd_pkg::HDR_BYTES)) begin
                           if (exp_v == '0) begin
                              ended_in = 1'b1;
                              phase_in = lzbd_pkg::PH_SKIP;
                           end else begin
                              phase_in = lzbd_pkg::PH_CODE;
                           end
                        end
                     end
                  end
                  lzbd_pkg::PH_CODE: begin
                     code_in  = req_in_byte;
                     rem_in   = 4'd8;
                     phase_in = lzbd_pkg::PH_ITEM;
                  end
                  lzbd_pkg::PH_ITEM: begin
                     if (code_ff[7]) begin
                        mem_we      = 1'b1;
                        mem_wdata   = req_in_byte;
                        wp_in       = wp_ff + AW'(1);
                        prod_in     = prod_ff + 32'd1;
                        chunk_in    = {56'd0, req_in_byte};
                        cnt_in      = lzbd_pkg::CNT_W'(1);
                        fin_elem_in = 1'b1;
                     end else begin
                        fref_in  = req_in_byte;
                        phase_in = lzbd_pkg::PH_REFLO;
                     end
                  end
                  lzbd_pkg::PH_REFLO: begin
                     dist_in = d_v;
                     if ({{(32-AW){1'b0}}, d_v} >= prod_ff) begin
                        st_in    = lzbd_pkg::STAT_DISTANCE;
                        ended_in = 1'b1;
                        phase_in = lzbd_pkg::PH_SKIP;
                     end else if (fref_ff[7:4] == 4'd0) begin
                        phase_in = lzbd_pkg::PH_REFEXT;
                     end else begin
                        left_in     = {5'd0, fref_ff[7:4]} + 9'(lzbd_pkg::NIB_LEN_BIAS);
                        fin_elem_in = 1'b1;
                        state_in    = lzbd_pkg::ST_RD;
                     end
                  end
                  lzbd_pkg::PH_REFEXT: begin
                     left_in     = {1'b0, req_in_byte} + 9'(lzbd_pkg::EXT_LEN_BIAS);
                     fin_elem_in = 1'b1;
                     state_in    = lzbd_pkg::ST_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         lzbd_pkg::ST_RD: begin
            // issue a history read, or flush a full chunk first, or finish once the copy is done
            if (left_ff != '0 && prod_ff < exp_ff) begin
               if (cnt_ff == lzbd_pkg::CNT_W'(lzbd_pkg::BYTES_PER_RESULT)) begin
                  obytes_in = chunk_ff;
                  ocnt_in   = cnt_ff;
                  ost_in    = lzbd_pkg::STAT_OK;
                  oend_in   = 1'b0;
                  olast_in  = 1'b0;
                  chunk_in  = '0;
                  cnt_in    = '0;
                  final_in  = 1'b0;
                  state_in  = lzbd_pkg::ST_OUT;
               end else begin
                  mem_re   = 1'b1;
                  state_in = lzbd_pkg::ST_WR;
               end
            end else begin
               state_in = lzbd_pkg::ST_FIN;
            end
         end
         lzbd_pkg::ST_WR: begin
            // write the copied byte back and append it to the chunk
            mem_we   = 1'b1;
            wp_in    = wp_ff + AW'(1);
            prod_in  = prod_ff + 32'd1;
            left_in  = left_ff - 9'd1;
            chunk_in = chunk_ff | ({56'd0, mem_rdata} << {cnt_ff[2:0], 3'b000});
            cnt_in   = cnt_ff + lzbd_pkg::CNT_W'(1);
            state_in = lzbd_pkg::ST_RD;
         end
         lzbd_pkg::ST_FIN: begin
            // close the element, check for truncation, present the last result if there is one
            if (fin_elem_ff) begin
               if (prod_ff >= exp_ff) begin
                  ph_v  = lzbd_pkg::PH_SKIP;
                  end_v = 1'b1;
               end else begin
                  code_in = {code_ff[6:0], 1'b0};
                  rem_v   = rem_ff - 4'd1;
                  rem_in  = rem_v;
                  ph_v    = (rem_v == 4'd0) ? lzbd_pkg::PH_CODE : lzbd_pkg::PH_ITEM;
               end
            end
            if (last_ff && !end_v && ph_v != lzbd_pkg::PH_SKIP) begin
               st_v  = lzbd_pkg::STAT_TRUNC;
               end_v = 1'b1;
            end
            phase_in = ph_v;
            if (last_ff) begin
               wp_in    = '0;
               prod_in  = '0;
               exp_in   = '0;
               hdr_in   = '0;
               code_in  = '0;
               rem_in   = '0;
               phase_in = lzbd_pkg::PH_HEADER;
               fref_in  = '0;
               dist_in  = '0;
            end
            if (cnt_ff != '0 || end_v) begin
               obytes_in = chunk_ff;
               ocnt_in   = cnt_ff;
               ost_in    = st_v;
               oend_in   = end_v;
               olast_in  = 1'b1;
               final_in  = 1'b1;
               state_in  = lzbd_pkg::ST_OUT;
            end else begin
               state_in = lzbd_pkg::ST_IDLE;
            end
         end
         lzbd_pkg::ST_OUT: begin
            // hold the result until taken
            if (rsp_ready) begin
               state_in = final_ff ? lzbd_pkg::ST_IDLE : lzbd_pkg::ST_RD;
            end
         end
         default: begin
            state_in = lzbd_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lzbd_pkg::ST_IDLE;
         phase_ff    <= lzbd_pkg::PH_HEADER;
         hdr_ff      <= '0;
         exp_ff      <= '0;
         prod_ff     <= '0;
         wp_ff       <= '0;
         code_ff     <= '0;
         rem_ff      <= '0;
         fref_ff     <= '0;
         dist_ff     <= '0;
         left_ff     <= '0;
         cnt_ff      <= '0;
         st_ff       <= lzbd_pkg::STAT_OK;
         ended_ff    <= 1'b0;
         last_ff     <= 1'b0;
         fin_elem_ff <= 1'b0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         hdr_ff      <= hdr_in;
         exp_ff      <= exp_in;
         prod_ff     <= prod_in;
         wp_ff       <= wp_in;
         code_ff     <= code_in;
         rem_ff      <= rem_in;
         fref_ff     <= fref_in;
         dist_ff     <= dist_in;
         left_ff     <= left_in;
         cnt_ff      <= cnt_in;
         st_ff       <= st_in;
         ended_ff    <= ended_in;
         last_ff     <= last_in;
         fin_elem_ff <= fin_elem_in;
         final_ff    <= final_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chunk_ff  <= chunk_in;
      obytes_ff <= obytes_in;
      ocnt_ff   <= ocnt_in;
      ost_ff    <= ost_in;
      oend_ff   <= oend_in;
      olast_ff  <= olast_in;
   end

   a_wr_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff == lzbd_pkg::ST_WR |=> prod_ff == $past(prod_ff) + 32'd1)
      else $error("copy write did not advance produced count");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      state_ff == lzbd_pkg::ST_FIN && last_ff |=>
      prod_ff == '0 && phase_ff == lzbd_pkg::PH_HEADER)
      else $error("last byte did not rearm the stream");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lzbd_pkg::STAT_OK |-> rsp_run_last && rsp_frame_end)
      else $error("error status on a non-final result");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count <= lzbd_pkg::CNT_W'(lzbd_pkg::BYTES_PER_RESULT))
      else $error("result byte count out of range");

   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == lzbd_pkg::ST_WR |-> prod_ff < exp_ff)
      else $error("copy ran past the declared size");

endmodule

>>> dv/lz_byte_stream_decompressor_test.sv
// lz_byte_stream_decompressor_test: self-checking testbench of the LZ byte stream decoder.
// Depends on lzbd_pkg and the lz_byte_stream_decompressor RTL; predicts every result
// transaction from the compressed stream and compares it field by field.
`timescale 1ns / 100ps

module lz_byte_stream_decompressor_test;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_in;
   } comp_byte_type;

   typedef struct packed {
      logic [63:0] out_bytes;
      logic [3:0]  byte_count;
      logic [1:0]  status;
      logic        frame_end;
      logic        run_last;
   } chunk_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_out_bytes;
   logic [3:0]  rsp_byte_count;
   logic [1:0]  rsp_status;
   logic        rsp_frame_end;
   logic        rsp_run_last;

   lz_byte_stream_decompressor u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_in_byte(req_in_byte), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_bytes(rsp_out_bytes), .rsp_byte_count(rsp_byte_count),
      .rsp_status(rsp_status), .rsp_frame_end(rsp_frame_end),
      .rsp_run_last(rsp_run_last)
   );

   always #5 clock = ~clock;

   // decoder shadow state
   logic [7:0]  hist_mem [0:lzbd_pkg::WINDOW_BYTES-1];
   logic [11:0] wr_ptr;
   logic [31:0] out_count;
   logic [31:0] decl_size;
   logic [4:0]  hdr_idx;
   logic [7:0]  flag_byte;
   logic [3:0]  flags_left;
   lzbd_pkg::phase_type dec_phase;
   logic [7:0]  ref_hi;
   logic [12:0] ref_dist;
   logic [7:0]  step_bytes [$];

   comp_byte_type pending_bytes [$];
   chunk_type     expected_chunks [$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_sender = 1'b0;
   bit          req_taken = 1'b0;
   int          mismatches = 0;

   task automatic emit_out(input logic [7:0] b);
      hist_mem[wr_ptr] = b;
      wr_ptr = wr_ptr + 12'd1;
      out_count = out_count + 1;
      step_bytes = {step_bytes, b};
   endtask

   task automatic copy_bytes(input int len);
      for (int i = 0; i < len && out_count < decl_size; i++)
         emit_out(hist_mem[wr_ptr - ref_dist[11:0]]);
   endtask

   function automatic bit close_element();
      if (out_count >= decl_size) begin
         dec_phase = lzbd_pkg::PH_SKIP;
         return 1'b1;
      end
      flag_byte = flag_byte << 1;
      flags_left = flags_left - 4'd1;
      dec_phase = (flags_left == 4'd0) ? lzbd_pkg::PH_CODE : lzbd_pkg::PH_ITEM;
      return 1'b0;
   endfunction

   task automatic clear_decoder();
      wr_ptr = 0; out_count = 0; decl_size = 0; hdr_idx = 0;
      flag_byte = 0; flags_left = 0; dec_phase = lzbd_pkg::PH_HEADER;
      ref_hi = 0; ref_dist = 0;
   endtask

   // predict the result transactions of one accepted byte
   task automatic decode_byte(input comp_byte_type t);
      logic [1:0] st;
      bit         ended;
      int         nres, cnt;
      chunk_type  c;
      st = lzbd_pkg::STAT_OK;
      ended = 1'b0;
      step_bytes.delete();
      case (dec_phase)
         lzbd_pkg::PH_HEADER: begin
            if (hdr_idx < 4 && t.in_byte != lzbd_pkg::magic_byte(hdr_idx[1:0])) begin
               st = lzbd_pkg::STAT_MAGIC;
               ended = 1'b1;
               dec_phase = lzbd_pkg::PH_SKIP;
            end else begin
               if (hdr_idx >= 4 && hdr_idx < 8) decl_size = {decl_size[23:0], t.in_byte};
               hdr_idx = hdr_idx + 5'd1;
               if (hdr_idx >= lzbd_pkg::HDR_BYTES) begin
                  if (decl_size == 0) begin
                     ended = 1'b1;
                     dec_phase = lzbd_pkg::PH_SKIP;
                  end else begin
                     dec_phase = lzbd_pkg::PH_CODE;
                  end
               end
            end
         end
         lzbd_pkg::PH_CODE: begin
            flag_byte = t.in_byte;
            flags_left = 4'd8;
            dec_phase = lzbd_pkg::PH_ITEM;
         end
         lzbd_pkg::PH_ITEM: begin
            if (flag_byte[7]) begin
               emit_out(t.in_byte);
               ended = close_element();
            end else begin
               ref_hi = t.in_byte;
               dec_phase = lzbd_pkg::PH_REFLO;
            end
         end
         lzbd_pkg::PH_REFLO: begin
            ref_dist = {1'b0, ref_hi[3:0], t.in_byte} + 13'd1;
            if (ref_dist > out_count) begin
               st = lzbd_pkg::STAT_DISTANCE;
               ended = 1'b1;
               dec_phase = lzbd_pkg::PH_SKIP;
            end else if (ref_hi[7:4] == 4'd0) begin
               dec_phase = lzbd_pkg::PH_REFEXT;
            end else begin
               copy_bytes(ref_hi[7:4] + lzbd_pkg::NIB_LEN_BIAS);
               ended = close_element();
            end
         end
         lzbd_pkg::PH_REFEXT: begin
            copy_bytes(t.in_byte + lzbd_pkg::EXT_LEN_BIAS);
            ended = close_element();
         end
         default: ;
      endcase
      if (t.last_in && !ended && dec_phase != lzbd_pkg::PH_SKIP) begin
         st = lzbd_pkg::STAT_TRUNC;
         ended = 1'b1;
      end
      if (t.last_in) clear_decoder();
      nres = (step_bytes.size() + lzbd_pkg::BYTES_PER_RESULT - 1) /
             lzbd_pkg::BYTES_PER_RESULT;
      if (nres == 0 && ended) nres = 1;
      for (int k = 0; k < nres; k++) begin
         c = '0;
         cnt = 0;
         while (cnt < lzbd_pkg::BYTES_PER_RESULT &&
                k * lzbd_pkg::BYTES_PER_RESULT + cnt < step_bytes.size()) begin
            c.out_bytes[8*cnt +: 8] = step_bytes[k * lzbd_pkg::BYTES_PER_RESULT + cnt];
            cnt++;
         end
         c.byte_count = 4'(cnt);
         c.run_last = (k == nres - 1);
         c.status = c.run_last ? st : lzbd_pkg::STAT_OK;
         c.frame_end = c.run_last && ended;
         expected_chunks = {expected_chunks, c};
      end
   endtask

   // driver: drop the byte taken at the last rising edge, then present the next
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) void'(pending_bytes.pop_front());
         if (req_valid && !req_taken) begin
            // hold the transaction until it is taken
         end else if (pending_bytes.size() > 0 && !hold_sender &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_in_byte <= pending_bytes[0].in_byte;
            req_last_in <= pending_bytes[0].last_in;
         end else begin
            req_valid <= 1'b0;
         end
         req_taken = 1'b0;
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predict on request acceptance, check on response acceptance
   always @(posedge clock) begin
      chunk_type got, exp_c;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            decode_byte({req_in_byte, req_last_in});
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_bytes, rsp_byte_count, rsp_status, rsp_frame_end, rsp_run_last};
            if (expected_chunks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               exp_c = expected_chunks.pop_front();
               if (got !== exp_c) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected bytes %h cnt %0d st %0d end %b last %b,",
                               " got bytes %h cnt %0d st %0d end %b last %b"},
                        exp_c.out_bytes, exp_c.byte_count, exp_c.status, exp_c.frame_end,
                        exp_c.run_last, got.out_bytes, got.byte_count, got.status,
                        got.frame_end, got.run_last);
               end
            end
         end
      end
   end

   task automatic put_byte(input logic [7:0] b, input logic last = 1'b0);
      comp_byte_type t;
      t = {b, last};
      pending_bytes = {pending_bytes, t};
   endtask

   task automatic put_header(input logic [31:0] size);
      put_byte(8'h59); put_byte(8'h61); put_byte(8'h7A); put_byte(8'h30);
      for (int i = 3; i >= 0; i--) put_byte(size[8*i +: 8]);
      for (int i = 0; i < 8; i++) put_byte(8'($urandom));
   endtask

   // stream of random literals and back-references, at times ending on a too-distant reference or cut short
   task automatic put_stream(input int size, input bit cut_short);
      int made, plen, ref_gap, len, nib;
      logic [7:0] flags;
      made = 0;
      put_header(size);
      while (made < size) begin
         flags = 8'($urandom);
         if (made == 0) flags[7] = 1'b1;
         put_byte(flags);
         for (int b = 7; b >= 0 && made < size; b--) begin
            if (flags[b] || made == 0) begin
               put_byte(8'($urandom));
               made++;
            end else begin
               ref_gap = $urandom_range(made < 4096 ? made : 4096, 1);
               if ($urandom_range(9) < 1 && made > 0)
                  ref_gap = made + 1 > 4096 ? 4096 : made + 1;
               nib = $urandom_range(15);
               if (nib == 0) begin
                  len = $urandom_range(3) == 0 ? 255 : $urandom_range(20);
                  put_byte({4'd0, 4'((ref_gap - 1) >> 8)});
                  put_byte(8'((ref_gap - 1) & 8'hFF));
                  if (ref_gap <= made) put_byte(8'(len));
                  plen = len + 18;
               end else begin
                  put_byte({4'(nib), 4'((ref_gap - 1) >> 8)});
                  put_byte(8'((ref_gap - 1) & 8'hFF));
                  plen = nib + 2;
               end
               if (ref_gap > made) begin
                  put_byte(8'($urandom), 1'b1);
                  return;
               end
               made += plen;
            end
            if (cut_short && $urandom_range(15) == 0) begin
               put_byte(8'($urandom), 1'b1);
               return;
            end
         end
      end
      for (int i = $urandom_range(2); i > 0; i--) put_byte(8'($urandom));
      put_byte(8'($urandom), 1'b1);
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || req_valid || expected_chunks.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      clear_decoder();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: bad magic at each position, ending on that byte
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < p; i++) put_byte(lzbd_pkg::magic_byte(2'(i)));
         put_byte(8'hFF, 1'b1);
      end
      // zero size, short header
      put_header(0); put_byte(8'hAA, 1'b1);
      put_byte(8'h59); put_byte(8'h61, 1'b1);
      // literal, then a reference reaching past it, caught before the length byte
      put_header(32'hFFFF_FFFF);
      put_byte(8'h80); put_byte(8'hAA); put_byte(8'h00); put_byte(8'h01);
      put_byte(8'h00, 1'b1);
      // longest copy, ending the stream exactly
      put_header(274);
      put_byte(8'h80); put_byte(8'hA5); put_byte(8'h00); put_byte(8'h00);
      put_byte(8'hFF); put_byte(8'h00, 1'b1);
      wait_drained();

      // random streams under each idling mix
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 82 : 34) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 82 : 34) : 0;
         put_stream($urandom_range(10, 1), $urandom_range(3) == 0);
         // pause the sender at a random point until every result is back
         repeat ($urandom_range(60, 10)) @(posedge clock);
         hold_sender = 1'b1;
         while (req_valid || expected_chunks.size() > 0) @(posedge clock);
         hold_sender = 1'b0;
         if ($urandom_range(1)) put_byte(8'($urandom), 1'($urandom_range(1)));
         wait_drained();
      end

      if (mismatches == 0)
         $display("lz_byte_stream_decompressor_test OK");
      else
         $display("lz_byte_stream_decompressor_test NOT OK");
      $finish;
   end

   initial begin
      #20ms;
      $display("lz_byte_stream_decompressor_test NOT OK");
      $finish;
   end

endmodule
